// ----- rtl/vtp_pkg.sv -----
package vtp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SCREEN_W_DEF  = 396;
  localparam int SCREEN_H_DEF  = 224;

  localparam int NUM_TRIG = 12;
  localparam int DIV_BITS = 32;

  localparam longint K_B_Q24       = 64'sd21361414;
  localparam longint K_C_Q24       = 64'sd6799549;
  localparam longint K_HALF_PI_Q24 = 64'sd26353589;

  localparam logic [2:0] REG_OBJECT_ANGLES   = 3'd0;
  localparam logic [2:0] REG_OBJECT_SCALE    = 3'd1;
  localparam logic [2:0] REG_OBJECT_POSITION = 3'd2;
  localparam logic [2:0] REG_CAMERA_ANGLES   = 3'd3;
  localparam logic [2:0] REG_CAMERA_POSITION = 3'd4;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               last_vertex;
  } in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic               last_out;
  } out_t;

  typedef logic [2:0][31:0] vec_t;
  typedef logic [NUM_TRIG-1:0][31:0] trig_t;

  typedef struct packed {
    vec_t v;
    logic last;
  } pl_t;

  function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b,
                                         input int fb);
    logic signed [63:0] p;
    logic signed [63:0] t;
    p = $signed(a) * $signed(b);
    t = p >>> fb;
    return t[31:0];
  endfunction

  function automatic logic [31:0] fx_from_int(input logic [15:0] v, input int fb);
    logic [31:0] e;
    e = {{16{v[15]}}, v};
    return e << fb;
  endfunction

  function automatic logic [31:0] fx_from_q12(input logic [15:0] v, input int fb);
    logic signed [31:0] e;
    e = {{16{v[15]}}, v};
    if (fb >= 12) begin
      return e << (fb - 12);
    end else begin
      return e >>> (12 - fb);
    end
  endfunction

endpackage

// ----- rtl/vtp_trig.sv -----
module vtp_trig #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [47:0]   obj_ang,
  input  logic [47:0]   cam_ang,
  output vtp_pkg::trig_t trig,
  output logic          busy
);
  import vtp_pkg::*;

  localparam longint KB_L = K_B_Q24 >>> (24 - FRAC_BITS);
  localparam longint KC_L = -(K_C_Q24 >>> (24 - FRAC_BITS));
  localparam longint HP_L = K_HALF_PI_Q24 >>> (24 - FRAC_BITS);
  localparam logic [31:0] KB      = KB_L[31:0];
  localparam logic [31:0] KC      = KC_L[31:0];
  localparam logic [31:0] HALF_PI = HP_L[31:0];

  logic [3:0]  cnt_r;
  logic        run_r;
  logic        s1_v_r, s2_v_r;
  logic [3:0]  s1_idx_r, s2_idx_r;
  logic [31:0] s1_t1_r, s1_t2_r, s2_t1_r, s2_t3_r;
  trig_t       trig_r;
  logic [15:0] field;
  logic [31:0] a0, a, abs_a;

  always_comb begin
    case (cnt_r[3:1])
      3'd0:    field = obj_ang[15:0];
      3'd1:    field = obj_ang[31:16];
      3'd2:    field = obj_ang[47:32];
      3'd3:    field = cam_ang[15:0];
      3'd4:    field = cam_ang[31:16];
      3'd5:    field = cam_ang[47:32];
      default: field = '0;
    endcase
    a0    = fx_from_q12(field, FRAC_BITS);
    a     = cnt_r[0] ? a0 + HALF_PI : a0;
    abs_a = a[31] ? (~a + 32'd1) : a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b1;
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(NUM_TRIG - 1)) begin
          run_r <= 1'b0;
        end
      end
      s1_v_r <= run_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r;
    s1_t1_r  <= fx_mul(KB, a, FRAC_BITS);
    s1_t2_r  <= fx_mul(a, abs_a, FRAC_BITS);
    s2_idx_r <= s1_idx_r;
    s2_t1_r  <= s1_t1_r;
    s2_t3_r  <= fx_mul(KC, s1_t2_r, FRAC_BITS);
    if (s2_v_r) begin
      trig_r[s2_idx_r] <= s2_t1_r + s2_t3_r;
    end
  end

  assign trig = trig_r;
  assign busy = run_r | s1_v_r | s2_v_r;

  assert property (@(posedge clk) disable iff (!rst_n) run_r |-> cnt_r < 4'(NUM_TRIG))
    else $error("trig sequencer count out of range");

endmodule

// ----- rtl/vtp_rot.sv -----
module vtp_rot #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
  parameter int AXIS      = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  vtp_pkg::pl_t in_pl,
  input  logic [31:0]  c,
  input  logic [31:0]  s,
  output logic         out_valid,
  output vtp_pkg::pl_t out_pl
);
  import vtp_pkg::*;

  localparam int I1 = (AXIS == 0) ? 1 : 0;
  localparam int I2 = (AXIS == 2) ? 1 : 2;

  logic        a_v_r, out_v_r;
  logic [31:0] pa_r, pb_r, pc_r, pd_r, keep_r;
  logic        a_last_r;
  pl_t         out_pl_r, out_pl_nxt;
  logic [31:0] x1, x2, x3;

  always_comb begin
    x1 = in_pl.v[I1];
    x2 = in_pl.v[I2];
    x3 = (AXIS == 1) ? (~x1 + 32'd1) : x1;
    out_pl_nxt.v[AXIS] = keep_r;
    out_pl_nxt.v[I1]   = (AXIS == 1) ? pa_r + pb_r : pa_r - pb_r;
    out_pl_nxt.v[I2]   = pc_r + pd_r;
    out_pl_nxt.last    = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      a_v_r   <= in_valid;
      out_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= fx_mul(x1, c, FRAC_BITS);
      pb_r     <= fx_mul(x2, s, FRAC_BITS);
      pc_r     <= fx_mul(x3, s, FRAC_BITS);
      pd_r     <= fx_mul(x2, c, FRAC_BITS);
      keep_r   <= in_pl.v[AXIS];
      a_last_r <= in_pl.last;
      out_pl_r <= out_pl_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_pl    = out_pl_r;

endmodule

// ----- rtl/vtp_div.sv -----
module vtp_div #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  vtp_pkg::pl_t in_pl,
  output logic         out_valid,
  output vtp_pkg::pl_t out_pl,
  output logic [31:0]  f
);
  import vtp_pkg::*;

  localparam logic [63:0] A64   = 64'd300 << FRAC_BITS;
  localparam logic [31:0] A_FX  = A64[31:0];
  localparam logic        A_NEG = A_FX[31];
  localparam logic [31:0] A_MAG = A_NEG ? (~A_FX + 32'd1) : A_FX;
  localparam logic [63:0] DVD   = {32'd0, A_MAG} << FRAC_BITS;
  localparam logic [31:0] REM0  = DVD[63:32];
  localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
  localparam logic [31:0] ONE   = ONE64[31:0];

  logic        v_r   [DIV_BITS+1];
  logic [31:0] rem_r [DIV_BITS+1];
  logic [31:0] q_r   [DIV_BITS+1];
  logic [31:0] d_r   [DIV_BITS+1];
  pl_t         pl_r  [DIV_BITS+1];
  logic [31:0] mz;

  assign mz = ($signed(in_pl.v[2]) < $signed(ONE)) ? ONE : in_pl.v[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM0;
      q_r[0]   <= '0;
      d_r[0]   <= mz;
      pl_r[0]  <= in_pl;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic [32:0] rs;
    logic        ge;

    assign rs = {rem_r[k], DVD[DIV_BITS-1-k]};
    assign ge = rs >= {1'b0, d_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? 32'(rs - {1'b0, d_r[k]}) : rs[31:0];
        q_r[k+1]   <= {q_r[k][30:0], ge};
        d_r[k+1]   <= d_r[k];
        pl_r[k+1]  <= pl_r[k];
      end
    end
  end

  assign out_valid = v_r[DIV_BITS];
  assign out_pl    = pl_r[DIV_BITS];
  assign f         = A_NEG ? (~q_r[DIV_BITS] + 32'd1) : q_r[DIV_BITS];

  assert property (@(posedge clk) disable iff (!rst_n)
      v_r[0] |-> ($signed(d_r[0]) >= $signed(ONE)))
    else $error("divisor below one after clamp");

endmodule

// ----- rtl/vertex_transform_projection_top.sv -----
// One vertex per cycle while nothing stalls; the transform, the divider (an input
// register and 32 steps) and the final scale are fully pipelined, and a stall on the
// output freezes every stage.
// Reset and every configuration write start a sine/cosine table refill on one
// shared unit, during which in_stall is held high.
module vertex_transform_projection_top #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_W  = vtp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H  = vtp_pkg::SCREEN_H_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vtp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output vtp_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import vtp_pkg::*;

  localparam logic [63:0] HW64   = 64'(SCREEN_W / 2) << FRAC_BITS;
  localparam logic [63:0] HH64   = 64'(SCREEN_H / 2) << FRAC_BITS;
  localparam logic [31:0] HALF_W = HW64[31:0];
  localparam logic [31:0] HALF_H = HH64[31:0];

  logic [47:0] obj_ang_r, obj_scale_r, obj_pos_r, cam_ang_r, cam_pos_r;
  logic        cfg_we, en, accept, trig_busy;
  trig_t       trig;

  logic        sc_v_r, tr_v_r, fm_v_r, out_v_r;
  pl_t         sc_pl_r, tr_pl_r;
  logic        obj_v [4];
  pl_t         obj_pl [4];
  logic        cam_v [4];
  pl_t         cam_pl [4];
  logic        dv_v;
  pl_t         dv_pl;
  logic [31:0] dv_f;
  logic [31:0] fm_x_r, fm_y_r, fm_z_r;
  logic        fm_last_r;
  out_t        out_r;
  logic [31:0] neg_y;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_ang_r   <= '0;
      obj_scale_r <= 48'h1000_1000_1000;
      obj_pos_r   <= '0;
      cam_ang_r   <= '0;
      cam_pos_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OBJECT_ANGLES:   obj_ang_r   <= cfg_data;
        REG_OBJECT_SCALE:    obj_scale_r <= cfg_data;
        REG_OBJECT_POSITION: obj_pos_r   <= cfg_data;
        REG_CAMERA_ANGLES:   cam_ang_r   <= cfg_data;
        REG_CAMERA_POSITION: cam_pos_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  vtp_trig #(.FRAC_BITS(FRAC_BITS)) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .obj_ang (obj_ang_r),
    .cam_ang (cam_ang_r),
    .trig    (trig),
    .busy    (trig_busy)
  );

  assign en       = !(out_v_r && out_stall);
  assign in_stall = !en || trig_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
      tr_v_r <= 1'b0;
      fm_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      sc_v_r  <= accept;
      tr_v_r  <= obj_v[3];
      fm_v_r  <= dv_v;
      out_v_r <= fm_v_r;
    end
  end

  assign neg_y = ~dv_pl.v[1] + 32'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_pl_r.v[0] <= fx_mul(fx_from_int(in_data.vertex_x, FRAC_BITS),
                             fx_from_q12(obj_scale_r[15:0], FRAC_BITS), FRAC_BITS);
      sc_pl_r.v[1] <= fx_mul(fx_from_int(in_data.vertex_y, FRAC_BITS),
                             fx_from_q12(obj_scale_r[31:16], FRAC_BITS), FRAC_BITS);
      sc_pl_r.v[2] <= fx_mul(fx_from_int(in_data.vertex_z, FRAC_BITS),
                             fx_from_q12(obj_scale_r[47:32], FRAC_BITS), FRAC_BITS);
      sc_pl_r.last <= in_data.last_vertex;

      tr_pl_r.v[0] <= obj_pl[3].v[0] + (fx_from_int(obj_pos_r[15:0], FRAC_BITS)
                      - fx_from_int(cam_pos_r[15:0], FRAC_BITS));
      tr_pl_r.v[1] <= obj_pl[3].v[1] + (fx_from_int(obj_pos_r[31:16], FRAC_BITS)
                      - fx_from_int(cam_pos_r[31:16], FRAC_BITS));
      tr_pl_r.v[2] <= obj_pl[3].v[2] + (fx_from_int(obj_pos_r[47:32], FRAC_BITS)
                      - fx_from_int(cam_pos_r[47:32], FRAC_BITS));
      tr_pl_r.last <= obj_pl[3].last;

      fm_x_r    <= fx_mul(dv_pl.v[0], dv_f, FRAC_BITS);
      fm_y_r    <= fx_mul(neg_y, dv_f, FRAC_BITS);
      fm_z_r    <= dv_pl.v[2];
      fm_last_r <= dv_pl.last;

      out_r.screen_x <= fm_x_r + HALF_W;
      out_r.screen_y <= fm_y_r + HALF_H;
      out_r.depth    <= fm_z_r;
      out_r.last_out <= fm_last_r;
    end
  end

  assign obj_v[0]  = sc_v_r;
  assign obj_pl[0] = sc_pl_r;
  assign cam_v[0]  = tr_v_r;
  assign cam_pl[0] = tr_pl_r;

  for (genvar j = 0; j < 3; j++) begin : g_rot
    vtp_rot #(.FRAC_BITS(FRAC_BITS), .AXIS(j)) u_obj_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (obj_v[j]),
      .in_pl     (obj_pl[j]),
      .c         (trig[2*j+1]),
      .s         (trig[2*j]),
      .out_valid (obj_v[j+1]),
      .out_pl    (obj_pl[j+1])
    );

    vtp_rot #(.FRAC_BITS(FRAC_BITS), .AXIS(j)) u_cam_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cam_v[j]),
      .in_pl     (cam_pl[j]),
      .c         (trig[2*j+7]),
      .s         (trig[2*j+6]),
      .out_valid (cam_v[j+1]),
      .out_pl    (cam_pl[j+1])
    );
  end

  vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cam_v[3]),
    .in_pl     (cam_pl[3]),
    .out_valid (dv_v),
    .out_pl    (dv_pl),
    .f         (dv_f)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n) cfg_valid && cfg_ready |=> in_stall)
    else $error("input taken while trig table refills");

  assert property (@(posedge clk) disable iff (!rst_n) out_v_r && out_stall |-> in_stall)
    else $error("input taken while pipeline is frozen");

endmodule
